// ===== sv/garp_pkg.sv =====
package garp_pkg;

    // Row store geometry and field widths
    localparam int ROWS     = 1024;
    localparam int ROW_AW   = $clog2(ROWS);
    localparam int IDX_W    = ROW_AW + 1;
    localparam int COORD_W  = 16;
    localparam int DIM_W    = 8;
    localparam int MIN_SIZE = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_BWD,
        ST_FWD,
        ST_CHECK,
        ST_WRITE,
        ST_SIZE,
        ST_EMIT
    } t_state;

    // Request to the atlas size unit
    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] widest;
        logic [IDX_W-1:0]   tallest;
    } t_size_req;

    // Answer of the atlas size unit
    typedef struct packed {
        logic             done;
        logic [COORD_W:0] width;
        logic [IDX_W-1:0] height;
    } t_size_rsp;

endpackage

// ===== sv/garp_in_if.sv =====
interface garp_in_if import garp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DIM_W-1:0] glyph_width;
    logic [DIM_W-1:0] glyph_height;
    logic             last_glyph;

    modport source (output valid, output glyph_width, output glyph_height,
                    output last_glyph, input ready);
    modport sink   (input valid, input glyph_width, input glyph_height,
                    input last_glyph, output ready);
endinterface

// ===== sv/garp_out_if.sv =====
interface garp_out_if import garp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pos_x;
    logic [ROW_AW-1:0]  pos_y;
    logic [COORD_W:0]   atlas_width;
    logic [IDX_W-1:0]   atlas_height;
    logic               overflow;

    modport source (output valid, output pos_x, output pos_y, output atlas_width,
                    output atlas_height, output overflow, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input atlas_width,
                    input atlas_height, input overflow, output ready);
endinterface

// ===== sv/garp_size_unit.sv =====
module garp_size_unit import garp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_size_req i_req,
    output t_size_rsp o_rsp
);

    logic               r_busy;
    logic [COORD_W:0]   r_pw;
    logic [IDX_W-1:0]   r_ph;
    logic [COORD_W-1:0] r_wv;
    logic [IDX_W-1:0]   r_hv;
    logic               grow_w;
    logic               grow_h;

    // Double each size while it is still below its extent
    assign grow_w = r_pw < {1'b0, r_wv};
    assign grow_h = r_ph < r_hv;

    assign o_rsp.done   = r_busy && !grow_w && !grow_h;
    assign o_rsp.width  = r_pw;
    assign o_rsp.height = r_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (!r_busy && i_req.start) begin
            r_busy <= 1'b1;
        end else if (o_rsp.done) begin
            r_busy <= 1'b0;
        end
    end

    // Load on start, then shift until both sizes cover their extents
    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            if (i_req.start) begin
                r_pw <= (COORD_W+1)'(MIN_SIZE);
                r_ph <= IDX_W'(MIN_SIZE);
                r_wv <= i_req.widest;
                r_hv <= i_req.tallest;
            end
        end else begin
            if (grow_w) begin
                r_pw <= {r_pw[COORD_W-1:0], 1'b0};
            end
            if (grow_h) begin
                r_ph <= {r_ph[IDX_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ===== sv/glyph_atlas_row_packer.sv =====
// Glyph atlas row packer. Each item carries one glyph rectangle and returns
// one result item with its x,y place in the atlas (or the overflow flag), and
// on the last glyph of a set also the power-of-two atlas size, after which the
// packer starts a fresh set. One item is in work at a time: ready is high only
// while the packer is idle. A glyph that opens a new line skips the sweeps. For
// a glyph that is fitted among the rows in use, the single read port of the
// row store is swept over L rows, with L the larger of the tallest extent and
// the glyph height h (tallest extent + 1 for a zero-height glyph), once
// downward to build block-suffix maxima and once upward for block-prefix
// maxima, which together give every window maximum, and then the covered rows
// are written one per cycle. A glyph of height 0 or 1 skips the downward
// sweep. The last glyph also runs the size search. There is no clearing pass
// after reset or between sets: rows at or above the tallest extent always
// read as zero.
module glyph_atlas_row_packer import garp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    garp_in_if.sink           i_in,
    garp_out_if.source        o_out
);

    t_state r_state, n_state;

    // Item and placement registers
    logic [DIM_W-1:0]   r_w, r_h;
    logic               r_last;
    logic [DIM_W-1:0]   r_sm1;
    logic [IDX_W-1:0]   r_len;
    logic [COORD_W-1:0] r_bx;
    logic [IDX_W-1:0]   r_by;
    logic [COORD_W-1:0] r_xw;
    logic               r_ovf;

    // Extents
    logic [COORD_W-1:0] r_widest;
    logic [IDX_W-1:0]   r_tall;

    // Scan sequencer
    logic [IDX_W-1:0]   r_cnt, r_left, r_ri;
    logic               r_rv, r_rg;
    logic [DIM_W-1:0]   r_bcnt, r_phase, r_fcnt;
    logic [COORD_W-1:0] r_sfx, r_pfx;

    // Row write sequencer
    logic [ROW_AW-1:0]  r_wadr;
    logic [DIM_W-1:0]   r_wcnt;

    // Output register
    logic               r_ov;
    logic [COORD_W-1:0] r_o_x;
    logic [ROW_AW-1:0]  r_o_y;
    logic [COORD_W:0]   r_o_aw;
    logic [IDX_W-1:0]   r_o_ah;
    logic               r_o_ovf;

    // Memories
    logic [COORD_W-1:0] row_mem [ROWS];
    logic [COORD_W-1:0] sfx_mem [ROWS];
    logic [COORD_W-1:0] r_row_q, r_sfx_q;

    // Combinational controls
    logic               in_acc, out_free, issue, pass_end;
    logic               newline, c_ovf;
    logic [COORD_W:0]   c_ext_w, c_xw;
    logic [DIM_W+3:0]   c_ext_h;
    logic [IDX_W:0]     c_yh;
    logic [IDX_W-1:0]   c_len, c_h, c_sm1, c_sfx_idx, c_y;
    logic [COORD_W-1:0] c_val, c_sfx_n, c_pfx_n, c_win;
    logic               c_blk_bot, c_cand;
    logic               row_we;
    t_size_req          size_req;
    t_size_rsp          size_rsp;

    garp_size_unit u_size (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (size_req),
        .o_rsp   (size_rsp)
    );

    assign size_req.start   = (r_state == ST_SIZE);
    assign size_req.widest  = r_widest;
    assign size_req.tallest = r_tall;

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_ov;
    assign o_out.pos_x        = r_o_x;
    assign o_out.pos_y        = r_o_y;
    assign o_out.atlas_width  = r_o_aw;
    assign o_out.atlas_height = r_o_ah;
    assign o_out.overflow     = r_o_ovf;

    assign in_acc   = i_in.valid && (r_state == ST_IDLE);
    assign out_free = !r_ov || o_out.ready;

    // Decide, check and window arithmetic
    always_comb begin
        c_h       = IDX_W'(r_h);
        c_sm1     = IDX_W'(r_sm1);
        c_ext_w   = {1'b0, r_widest} + (COORD_W+1)'(r_w);
        c_ext_h   = (DIM_W+4)'(r_tall) + (DIM_W+4)'(r_h);
        newline   = c_ext_w > (COORD_W+1)'(c_ext_h);
        if (r_h == '0) begin
            c_len = r_tall + IDX_W'(1);
        end else begin
            c_len = (r_tall > c_h) ? r_tall : c_h;
        end

        c_yh  = {1'b0, r_by} + (IDX_W+1)'(r_h);
        c_xw  = {1'b0, r_bx} + (COORD_W+1)'(r_w);
        c_ovf = (r_by >= IDX_W'(ROWS)) || (c_yh > (IDX_W+1)'(ROWS)) || c_xw[COORD_W];

        issue     = ((r_state == ST_BWD) || (r_state == ST_FWD)) && (r_left != '0);
        pass_end  = (r_left == '0) && !r_rv;
        c_sfx_idx = r_cnt - c_sm1;

        c_val     = r_rg ? r_row_q : '0;
        c_sfx_n   = ((r_bcnt == '0) || (c_val > r_sfx)) ? c_val : r_sfx;
        c_blk_bot = (r_ri == '0) || (r_fcnt == r_sm1);
        c_pfx_n   = (c_blk_bot || (c_val > r_pfx)) ? c_val : r_pfx;
        if (r_sm1 == '0) begin
            c_win = c_val;
        end else begin
            c_win = (r_sfx_q > c_pfx_n) ? r_sfx_q : c_pfx_n;
        end
        c_cand = r_ri >= c_sm1;
        c_y    = r_ri - c_sm1;

        row_we = (r_state == ST_WRITE);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (newline) begin
                    n_state = ST_CHECK;
                end else if (r_h > DIM_W'(1)) begin
                    n_state = ST_BWD;
                end else begin
                    n_state = ST_FWD;
                end
            end
            ST_BWD: begin
                if (pass_end) begin
                    n_state = ST_FWD;
                end
            end
            ST_FWD: begin
                if (pass_end) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!c_ovf && (r_h != '0)) begin
                    n_state = ST_WRITE;
                end else if (r_last) begin
                    n_state = ST_SIZE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_WRITE: begin
                if (r_wcnt == DIM_W'(1)) begin
                    n_state = r_last ? ST_SIZE : ST_EMIT;
                end
            end
            ST_SIZE: begin
                if (size_rsp.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rv     <= 1'b0;
            r_ov     <= 1'b0;
            r_widest <= '0;
            r_tall   <= '0;
        end else begin
            r_state <= n_state;
            r_rv    <= issue;
            // Raise extents for a recorded glyph
            if ((r_state == ST_CHECK) && !c_ovf) begin
                if (c_yh > (IDX_W+1)'(r_tall)) begin
                    r_tall <= c_yh[IDX_W-1:0];
                end
                if (c_xw[COORD_W-1:0] > r_widest) begin
                    r_widest <= c_xw[COORD_W-1:0];
                end
            end
            // Hand over the result; drop the set after its last glyph
            if ((r_state == ST_EMIT) && out_free) begin
                r_ov <= 1'b1;
                if (r_last) begin
                    r_widest <= '0;
                    r_tall   <= '0;
                end
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        // Track the read pipeline
        r_ri <= r_cnt;
        r_rg <= r_cnt < r_tall;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_w    <= i_in.glyph_width;
                    r_h    <= i_in.glyph_height;
                    r_last <= i_in.last_glyph;
                end
            end
            ST_DECIDE: begin
                r_sm1  <= (r_h == '0) ? '0 : r_h - DIM_W'(1);
                r_len  <= c_len;
                r_left <= c_len;
                r_bcnt <= '0;
                r_fcnt <= '0;
                if (newline) begin
                    r_bx <= '0;
                    r_by <= r_tall;
                end else if (r_h > DIM_W'(1)) begin
                    r_cnt <= c_len - IDX_W'(1);
                end else begin
                    r_cnt <= '0;
                end
            end
            ST_BWD: begin
                if (issue) begin
                    r_cnt  <= r_cnt - IDX_W'(1);
                    r_left <= r_left - IDX_W'(1);
                end
                // Build suffix maxima within blocks aligned from the top
                if (r_rv) begin
                    r_sfx  <= c_sfx_n;
                    r_bcnt <= (r_bcnt == r_sm1) ? '0 : r_bcnt + DIM_W'(1);
                    if (r_ri == '0) begin
                        r_phase <= r_bcnt;
                    end
                end
                if (pass_end) begin
                    r_cnt  <= '0;
                    r_left <= r_len;
                    r_fcnt <= r_phase;
                end
            end
            ST_FWD: begin
                if (issue) begin
                    r_cnt  <= r_cnt + IDX_W'(1);
                    r_left <= r_left - IDX_W'(1);
                end
                // Combine prefix and suffix maxima; keep the first lowest window
                if (r_rv) begin
                    r_pfx  <= c_pfx_n;
                    r_fcnt <= (r_fcnt == '0) ? r_sm1 : r_fcnt - DIM_W'(1);
                    if (c_cand && ((r_ri == c_sm1) || (c_win < r_bx))) begin
                        r_bx <= c_win;
                        r_by <= c_y;
                    end
                end
            end
            ST_CHECK: begin
                r_ovf  <= c_ovf;
                r_xw   <= c_xw[COORD_W-1:0];
                r_wadr <= r_by[ROW_AW-1:0];
                r_wcnt <= r_h;
            end
            ST_WRITE: begin
                r_wadr <= r_wadr + ROW_AW'(1);
                r_wcnt <= r_wcnt - DIM_W'(1);
            end
            ST_EMIT: begin
                if (out_free) begin
                    r_o_x   <= r_ovf ? '0 : r_bx;
                    r_o_y   <= r_ovf ? '0 : r_by[ROW_AW-1:0];
                    r_o_aw  <= r_last ? size_rsp.width : '0;
                    r_o_ah  <= r_last ? size_rsp.height : '0;
                    r_o_ovf <= r_ovf;
                end
            end
            default: begin
            end
        endcase
    end

    // Row store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            row_mem[r_wadr] <= r_xw;
        end
        r_row_q <= row_mem[r_cnt[ROW_AW-1:0]];
    end

    // Block-suffix store, filled by the downward pass
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_BWD) && r_rv) begin
            sfx_mem[r_ri[ROW_AW-1:0]] <= c_sfx_n;
        end
        r_sfx_q <= sfx_mem[c_sfx_idx[ROW_AW-1:0]];
    end

endmodule
